### rtl/slrp_pkg.sv
// shared constants, types and register indexes of the linear ramp stepper pulser
// no dependencies
package slrp_pkg;

  localparam int RAMP_MAX  = 64;
  localparam int IDX_W     = $clog2(RAMP_MAX);
  localparam int STEP_W    = $clog2(RAMP_MAX + 1);
  localparam int DVS_W     = IDX_W + 2;
  localparam int FIX_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int DELAY_W   = 16;
  localparam int DIV_STEPS = FIX_W + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int CFG_W     = 32;
  localparam int ADDR_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS    = 2'd2;

  localparam logic [FIX_W-1:0]   INITIAL_DELAY_RST = 32'd2031616;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST     = 16'd1;
  localparam logic [STEP_W-1:0]  RAMP_STEPS_RST    = 7'd50;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACCEL,
    PH_DECEL
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDW,
    ST_EVAL,
    ST_RD2,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } st_t;

endpackage

### rtl/slrp_in_if.sv
// input channel of the linear ramp stepper pulser: one timebase tick per transaction
// no dependencies
interface slrp_in_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

### rtl/slrp_out_if.sv
// result channel of the linear ramp stepper pulser: one result per tick
// depends on slrp_pkg
interface slrp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         pulse_level;
  logic                         busy_res;
  logic                         move_done;
  logic [slrp_pkg::DELAY_W-1:0] current_delay;

  modport source (output valid, output pulse_level, output busy_res, output move_done,
                  output current_delay, input ready);
  modport sink (input valid, input pulse_level, input busy_res, input move_done,
                input current_delay, output ready);
endinterface

### rtl/slrp_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module slrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/stepper_linear_ramp_pulser.sv
// top level of the linear ramp stepper pulser: tick sequencer, delay ram, bit-serial divider
// depends on slrp_pkg, slrp_in_if, slrp_out_if, slrp_ram
//
// Each input transaction is one timebase tick and yields one result. A tick while no move
// runs goes straight to output; a start tick writes ram entry zero and evaluates; a tick inside
// a move does delay ram read, evaluate, optional second ram read for the next step; a tick that
// ends an acceleration step before the last runs the bit-serial divider for 2*d/(4n+1).
// Acceleration delays are written to a 64 entry ram and read back in reverse order during
// deceleration. The next tick is accepted while the previous result waits in the output
// register; a result that is still held when the next one is ready stalls the sequencer.
module stepper_linear_ramp_pulser (
  input  logic                                clk,
  input  logic                                rst_n,
  slrp_in_if.sink                             in_ch,
  slrp_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [slrp_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [slrp_pkg::CFG_W-1:0]          cfg_pwdata,
  output logic [slrp_pkg::CFG_W-1:0]          cfg_prdata,
  output logic                                cfg_pready
);

  localparam int IW = slrp_pkg::IDX_W;
  localparam int SW = slrp_pkg::STEP_W;
  localparam int DW = slrp_pkg::DELAY_W;
  localparam int FW = slrp_pkg::FIX_W;
  localparam int VW = slrp_pkg::DVS_W;
  localparam int CW = slrp_pkg::DCNT_W;

  function automatic logic [FW-1:0] clamp_fix(input logic [FW-1:0] d, input logic [DW-1:0] m);
    logic [FW-1:0] r;
    r = d;
    if (d[FW-1:slrp_pkg::FRAC_W] <= m) begin
      r = {m, {slrp_pkg::FRAC_W{1'b0}}};
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] load_cnt(input logic [DW-1:0] v);
    return (v == '0) ? DW'(1) : v;
  endfunction

  // configuration
  logic [FW-1:0] init_delay_r;
  logic [DW-1:0] min_delay_r;
  logic [SW-1:0] ramp_r;
  logic          cfg_wr;
  logic [slrp_pkg::CFG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_delay_r <= slrp_pkg::INITIAL_DELAY_RST;
      min_delay_r  <= slrp_pkg::MIN_DELAY_RST;
      ramp_r       <= slrp_pkg::RAMP_STEPS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        slrp_pkg::CFG_INITIAL_DELAY: init_delay_r <= cfg_pwdata;
        slrp_pkg::CFG_MIN_DELAY:     min_delay_r  <= cfg_pwdata[DW-1:0];
        slrp_pkg::CFG_RAMP_STEPS:    ramp_r       <= cfg_pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      slrp_pkg::CFG_INITIAL_DELAY: cfg_prdata = init_delay_r;
      slrp_pkg::CFG_MIN_DELAY:     cfg_prdata = {{(slrp_pkg::CFG_W-DW){1'b0}}, min_delay_r};
      slrp_pkg::CFG_RAMP_STEPS:    cfg_prdata = {{(slrp_pkg::CFG_W-SW){1'b0}}, ramp_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  logic [SW-1:0] eff_ramp;
  logic [DW-1:0] eff_min;

  always_comb begin
    eff_ramp = ramp_r;
    if (ramp_r == '0) begin
      eff_ramp = SW'(1);
    end else if (ramp_r > SW'(slrp_pkg::RAMP_MAX)) begin
      eff_ramp = SW'(slrp_pkg::RAMP_MAX);
    end
    eff_min = (min_delay_r == '0) ? DW'(1) : min_delay_r;
  end

  // state
  slrp_pkg::st_t    st_r, st_nxt;
  slrp_pkg::phase_t phase_r, phase_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic [FW-1:0]    dfix_r, dfix_nxt;
  logic             high_r, high_nxt;
  logic [DW-1:0]    cnt_r, cnt_nxt;
  logic             pin_r, pin_nxt;
  logic [DW-1:0]    cur_r, cur_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [FW:0]      quo_r, quo_nxt;
  logic [VW-1:0]    dvs_r, dvs_nxt;
  logic [CW-1:0]    dcnt_r, dcnt_nxt;
  logic             res_pulse_r, res_pulse_nxt;
  logic             res_busy_r, res_busy_nxt;
  logic             res_done_r, res_done_nxt;
  logic [DW-1:0]    res_delay_r, res_delay_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             o_pulse_r, o_busy_r, o_done_r;
  logic [DW-1:0]    o_delay_r;
  logic             out_load;

  // delay ram
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  slrp_ram #(
    .WIDTH (DW),
    .DEPTH (slrp_pkg::RAMP_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic          in_acc;
  logic [SW-1:0] cur_idx;
  logic [SW-1:0] step_inc;
  logic [DW-1:0] cnt_dec;
  logic [FW-1:0] dstart;
  logic [FW-1:0] dupd;
  logic [VW:0]   trial;
  logic          q_bit;

  assign in_ch.ready = (st_r == slrp_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    cur_idx = step_r;
    if (phase_r == slrp_pkg::PH_DECEL) begin
      cur_idx = (step_r < eff_ramp) ? SW'(eff_ramp - SW'(1) - step_r) : '0;
    end
    step_inc = SW'(step_r + SW'(1));
    cnt_dec  = (cnt_r != '0) ? DW'(cnt_r - DW'(1)) : '0;
    dstart   = clamp_fix(init_delay_r, eff_min);
    dupd     = clamp_fix(FW'(dfix_r - quo_r[FW-1:0]), eff_min);
    trial    = {rem_r, quo_r[FW]};
    q_bit    = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    dfix_nxt      = dfix_r;
    high_nxt      = high_r;
    cnt_nxt       = cnt_r;
    pin_nxt       = pin_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    dcnt_nxt      = dcnt_r;
    res_pulse_nxt = res_pulse_r;
    res_busy_nxt  = res_busy_r;
    res_done_nxt  = res_done_r;
    res_delay_nxt = res_delay_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = cur_idx[IW-1:0];
    out_load      = 1'b0;

    case (st_r)
      slrp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (phase_r == slrp_pkg::PH_IDLE) begin
            if (!in_ch.start_req) begin
              res_pulse_nxt = pin_r;
              res_busy_nxt  = 1'b0;
              res_done_nxt  = 1'b0;
              res_delay_nxt = '0;
              st_nxt        = slrp_pkg::ST_OUT;
            end else begin
              // start of a move: first delay goes straight to entry zero
              phase_nxt = slrp_pkg::PH_ACCEL;
              step_nxt  = '0;
              dfix_nxt  = dstart;
              high_nxt  = 1'b0;
              cnt_nxt   = load_cnt(dstart[FW-1:slrp_pkg::FRAC_W]);
              cur_nxt   = dstart[FW-1:slrp_pkg::FRAC_W];
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = dstart[FW-1:slrp_pkg::FRAC_W];
              st_nxt    = slrp_pkg::ST_EVAL;
            end
          end else begin
            st_nxt = slrp_pkg::ST_RDW;
          end
        end
      end

      slrp_pkg::ST_RDW: begin
        cur_nxt = ram_rdata;
        st_nxt  = slrp_pkg::ST_EVAL;
      end

      slrp_pkg::ST_EVAL: begin
        pin_nxt       = high_r;
        res_pulse_nxt = high_r;
        res_busy_nxt  = 1'b1;
        res_done_nxt  = 1'b0;
        res_delay_nxt = cur_r;
        st_nxt        = slrp_pkg::ST_OUT;
        if (cnt_dec != '0) begin
          cnt_nxt = cnt_dec;
        end else if (!high_r) begin
          high_nxt = 1'b1;
          cnt_nxt  = load_cnt(cur_r);
        end else begin
          high_nxt = 1'b0;
          cnt_nxt  = cnt_dec;
          if (phase_r == slrp_pkg::PH_ACCEL) begin
            if (step_inc >= eff_ramp) begin
              phase_nxt = slrp_pkg::PH_DECEL;
              step_nxt  = '0;
              ram_raddr = IW'(eff_ramp - SW'(1));
              st_nxt    = slrp_pkg::ST_RD2;
            end else begin
              step_nxt = step_inc;
              rem_nxt  = '0;
              quo_nxt  = {dfix_r, 1'b0};
              dvs_nxt  = {step_inc[IW-1:0], 2'b01};
              dcnt_nxt = '0;
              st_nxt   = slrp_pkg::ST_DIV;
            end
          end else if (step_inc >= eff_ramp) begin
            phase_nxt    = slrp_pkg::PH_IDLE;
            step_nxt     = '0;
            res_done_nxt = 1'b1;
          end else begin
            step_nxt  = step_inc;
            ram_raddr = IW'(eff_ramp - SW'(1) - step_inc);
            st_nxt    = slrp_pkg::ST_RD2;
          end
        end
      end

      slrp_pkg::ST_RD2: begin
        cnt_nxt = load_cnt(ram_rdata);
        st_nxt  = slrp_pkg::ST_OUT;
      end

      slrp_pkg::ST_DIV: begin
        rem_nxt  = q_bit ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
        quo_nxt  = {quo_r[FW-1:0], q_bit};
        dcnt_nxt = CW'(dcnt_r + CW'(1));
        if (dcnt_r == CW'(slrp_pkg::DIV_STEPS - 1)) begin
          st_nxt = slrp_pkg::ST_FIN;
        end
      end

      slrp_pkg::ST_FIN: begin
        dfix_nxt  = dupd;
        ram_we    = 1'b1;
        ram_waddr = step_r[IW-1:0];
        ram_wdata = dupd[FW-1:slrp_pkg::FRAC_W];
        cnt_nxt   = load_cnt(dupd[FW-1:slrp_pkg::FRAC_W]);
        st_nxt    = slrp_pkg::ST_OUT;
      end

      slrp_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          st_nxt   = slrp_pkg::ST_IDLE;
        end
      end

      default: st_nxt = slrp_pkg::ST_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= slrp_pkg::ST_IDLE;
      phase_r     <= slrp_pkg::PH_IDLE;
      step_r      <= '0;
      dfix_r      <= '0;
      high_r      <= 1'b0;
      cnt_r       <= '0;
      pin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      dfix_r      <= dfix_nxt;
      high_r      <= high_nxt;
      cnt_r       <= cnt_nxt;
      pin_r       <= pin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dvs_r       <= dvs_nxt;
    dcnt_r      <= dcnt_nxt;
    res_pulse_r <= res_pulse_nxt;
    res_busy_r  <= res_busy_nxt;
    res_done_r  <= res_done_nxt;
    res_delay_r <= res_delay_nxt;
    if (out_load) begin
      o_pulse_r <= res_pulse_r;
      o_busy_r  <= res_busy_r;
      o_done_r  <= res_done_r;
      o_delay_r <= res_delay_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pulse_level   = o_pulse_r;
  assign out_ch.busy_res      = o_busy_r;
  assign out_ch.move_done     = o_done_r;
  assign out_ch.current_delay = o_delay_r;

  // checks
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.move_done |-> out_ch.busy_res)
    else $error("move_done without busy_res");

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r != slrp_pkg::ST_IDLE)
    else $error("accepted tick not processed");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != slrp_pkg::PH_IDLE |-> step_r < SW'(slrp_pkg::RAMP_MAX))
    else $error("step number beyond ramp store");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == slrp_pkg::ST_DIV |-> dcnt_r < CW'(slrp_pkg::DIV_STEPS) && dvs_r[1:0] == 2'b01)
    else $error("divider out of sequence");

  a_idle_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.busy_res |-> out_ch.current_delay == '0)
    else $error("delay reported while idle");

endmodule

### tb/tb_stepper_linear_ramp_pulser.sv
`timescale 1ns / 1ps
// testbench of stepper_linear_ramp_pulser: apb register writes and timebase tick transactions,
// each result checked against a cycle-free model of the ramp, store and pulse timing
// depends on slrp_pkg, slrp_in_if, slrp_out_if and the rtl of the block
module tb_stepper_linear_ramp_pulser;

  localparam int     ITEM_TARGET  = 650;
  localparam int     QUIET_FROM   = 560;
  localparam int     DRAIN_CYCLES = 64;
  localparam longint CYCLE_LIMIT  = 1000000;

  localparam int DELAY_W   = slrp_pkg::DELAY_W;
  localparam int ADDR_W    = slrp_pkg::ADDR_W;
  localparam int CFG_W     = slrp_pkg::CFG_W;
  localparam int FIX_W     = slrp_pkg::FIX_W;
  localparam int FRAC_W    = slrp_pkg::FRAC_W;
  localparam int STEP_W    = slrp_pkg::STEP_W;
  localparam int RAMP_MAX  = slrp_pkg::RAMP_MAX;
  localparam int CFG_IDX_W = slrp_pkg::CFG_IDX_W;

  typedef struct packed {
    logic               pulse_level;
    logic               busy_res;
    logic               move_done;
    logic [DELAY_W-1:0] current_delay;
  } tick_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic src_valid = 1'b0;
  logic src_start = 1'b0;
  logic snk_ready = 1'b0;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_W-1:0]  cfg_pwdata = '0;
  logic [CFG_W-1:0]  cfg_prdata;
  logic              cfg_pready;

  slrp_in_if  tick_if ();
  slrp_out_if res_if ();

  assign tick_if.valid     = src_valid;
  assign tick_if.start_req = src_start;
  assign res_if.ready      = snk_ready;

  stepper_linear_ramp_pulser DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (tick_if),
    .out_ch      (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // register copies and move state of the model
  logic [FIX_W-1:0]   cf_init = slrp_pkg::INITIAL_DELAY_RST;
  logic [DELAY_W-1:0] cf_min = slrp_pkg::MIN_DELAY_RST;
  logic [STEP_W-1:0]  cf_ramp = slrp_pkg::RAMP_STEPS_RST;
  slrp_pkg::phase_t   mv_phase = slrp_pkg::PH_IDLE;
  logic [STEP_W-1:0]  mv_step = '0;
  logic [FIX_W-1:0]   mv_delay = '0;
  logic [DELAY_W-1:0] delay_ram [RAMP_MAX];
  logic               mv_high = 1'b0;
  logic [DELAY_W-1:0] half_left = '0;
  logic               pin_now = 1'b0;

  logic      pending_ticks [$];
  tick_res_t expected_samples [$];
  tick_res_t want_res;
  int        send_gap = 0;
  int        recv_stall = 0;
  logic      quiet = 1'b0;
  int        items_pushed = 0;
  int        results_seen = 0;
  int        errors = 0;
  longint    cycle_count = 0;

  function automatic int unsigned ramp_len();
    int unsigned r;
    r = cf_ramp;
    if (r < 1) r = 1;
    if (r > RAMP_MAX) r = RAMP_MAX;
    return r;
  endfunction

  function automatic logic [DELAY_W-1:0] min_len();
    return (cf_min == '0) ? DELAY_W'(1) : cf_min;
  endfunction

  function automatic void clamp_and_keep(input int unsigned idx);
    if (mv_delay[FIX_W-1:FRAC_W] <= min_len()) mv_delay = {min_len(), {FRAC_W{1'b0}}};
    if (idx < RAMP_MAX) delay_ram[idx] = mv_delay[FIX_W-1:FRAC_W];
  endfunction

  function automatic logic [DELAY_W-1:0] ram_at(input int unsigned idx);
    return (idx < RAMP_MAX) ? delay_ram[idx] : '0;
  endfunction

  function automatic int unsigned ram_index();
    int unsigned r;
    r = ramp_len();
    if (mv_phase == slrp_pkg::PH_DECEL) return (mv_step < r) ? r - 1 - mv_step : 0;
    return mv_step;
  endfunction

  function automatic logic [DELAY_W-1:0] half_load(input logic [DELAY_W-1:0] d);
    return (d == '0) ? DELAY_W'(1) : d;
  endfunction

  // advances the move by one timebase tick and returns the result it drives: pin sample, busy, move done and delay
  function automatic tick_res_t ramp_tick(input logic start);
    tick_res_t          res;
    logic [DELAY_W-1:0] cur;
    int unsigned        r;
    logic [63:0]        quot;
    res = '0;
    if (mv_phase == slrp_pkg::PH_IDLE) begin
      if (!start) begin
        res.pulse_level = pin_now;
        return res;
      end
      mv_phase = slrp_pkg::PH_ACCEL;
      mv_step = '0;
      mv_delay = cf_init;
      clamp_and_keep(0);
      mv_high = 1'b0;
      half_left = half_load(ram_at(0));
    end
    cur = ram_at(ram_index());
    pin_now = mv_high;
    res.pulse_level = pin_now;
    res.busy_res = 1'b1;
    res.current_delay = cur;
    if (half_left != '0) half_left = half_left - 1'b1;
    if (half_left == '0) begin
      if (!mv_high) begin
        mv_high = 1'b1;
        half_left = half_load(cur);
      end else begin
        r = ramp_len();
        mv_high = 1'b0;
        mv_step = mv_step + 1'b1;
        if (mv_phase == slrp_pkg::PH_ACCEL) begin
          if (mv_step >= r) begin
            mv_phase = slrp_pkg::PH_DECEL;
            mv_step = '0;
          end else begin
            quot = (64'(mv_delay) * 2) / (64'(mv_step) * 4 + 1);
            mv_delay = mv_delay - quot[FIX_W-1:0];
            clamp_and_keep(mv_step);
          end
        end else if (mv_step >= r) begin
          mv_phase = slrp_pkg::PH_IDLE;
          mv_step = '0;
          res.move_done = 1'b1;
        end
        if (mv_phase != slrp_pkg::PH_IDLE) half_left = half_load(ram_at(ram_index()));
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  task automatic push_tick(input logic start);
    pending_ticks.push_back(start);
    items_pushed++;
    if (items_pushed >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'({idx, 2'b00});
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      slrp_pkg::CFG_INITIAL_DELAY: cf_init = val;
      slrp_pkg::CFG_MIN_DELAY:     cf_min = val[DELAY_W-1:0];
      slrp_pkg::CFG_RAMP_STEPS:    cf_ramp = val[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic load_config(input logic [FIX_W-1:0] init, input logic [DELAY_W-1:0] mind,
                             input logic [STEP_W-1:0] steps);
    write_reg(slrp_pkg::CFG_INITIAL_DELAY, init);
    write_reg(slrp_pkg::CFG_MIN_DELAY, CFG_W'(mind));
    write_reg(slrp_pkg::CFG_RAMP_STEPS, CFG_W'(steps));
  endtask

  // keep ticking until the move is over, then wait for every result
  task automatic close_phase();
    while (pending_ticks.size() != 0 || mv_phase != slrp_pkg::PH_IDLE) begin
      if (pending_ticks.size() < 2 && mv_phase != slrp_pkg::PH_IDLE)
        repeat (4) push_tick($urandom_range(0, 7) == 0);
      @(negedge clk);
    end
    while (expected_samples.size() != 0) @(negedge clk);
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
      snk_ready <= 1'b0;
    end else begin
      if (send_gap > 0) begin
        send_gap--;
        src_valid <= 1'b0;
      end else begin
        src_valid <= (pending_ticks.size() > 0);
        src_start <= (pending_ticks.size() > 0) ? pending_ticks[0] : 1'b0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (tick_if.valid && tick_if.ready) begin
        expected_samples.push_back(ramp_tick(pending_ticks.pop_front()));
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 11);
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected transaction, valid", 1, 0);
        end else begin
          want_res = expected_samples.pop_front();
          if (res_if.pulse_level !== want_res.pulse_level)
            report_mismatch("pulse_level", res_if.pulse_level, want_res.pulse_level);
          if (res_if.busy_res !== want_res.busy_res)
            report_mismatch("busy_res", res_if.busy_res, want_res.busy_res);
          if (res_if.move_done !== want_res.move_done)
            report_mismatch("move_done", res_if.move_done, want_res.move_done);
          if (res_if.current_delay !== want_res.current_delay)
            report_mismatch("current_delay", res_if.current_delay, want_res.current_delay);
        end
        if (!quiet && $urandom_range(0, 3) == 0) recv_stall = $urandom_range(1, 11);
      end
    end
  end

  initial begin
    logic [FIX_W-1:0]   r_init;
    logic [DELAY_W-1:0] r_min;
    logic [STEP_W-1:0]  r_ramp;
    foreach (delay_ram[i]) delay_ram[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle ticks at reset settings, pin low
    repeat (4) push_tick(1'b0);
    close_phase();

    // zero ramp and zero floor, smallest initial delay; starts while busy are ignored
    load_config(32'h0001_0000, 16'd0, 7'd0);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    close_phase();

    // largest register values, idle only
    load_config(32'hFFFF_FFFF, 16'hFFFF, 7'd127);
    repeat (3) push_tick(1'b0);
    close_phase();

    // ramp above the store depth, delay pinned at the floor
    load_config(32'h0001_8000, 16'd1, 7'd127);
    push_tick(1'b0);
    push_tick(1'b1);
    close_phase();

    while (items_pushed < ITEM_TARGET) begin
      r_ramp = STEP_W'(($urandom_range(0, 9) == 0) ? $urandom_range(60, 127)
                                                    : $urandom_range(0, 12));
      if (r_ramp > 12 || $urandom_range(0, 3) != 0) r_min = DELAY_W'($urandom_range(0, 1));
      else r_min = DELAY_W'($urandom_range(2, 4));
      r_init = {16'($urandom_range(1, 9)), 16'($urandom)};
      load_config(r_init, r_min, r_ramp);
      repeat ($urandom_range(0, 3)) push_tick(1'b0);
      push_tick($urandom_range(0, 7) != 0);
      close_phase();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_samples.size() != 0)
      report_mismatch("missing transactions, count", 0, expected_samples.size());
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
